// ===== rtl/spr_pkg.sv =====
// Shared types, character codes and digit helpers for the servo reply parser.
`default_nettype none

package spr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdW     = 10;
  localparam int unsigned PulseW  = 14;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 14;
  localparam int unsigned NumCells = 9;

  localparam logic [ByteW-1:0] ChHash = 8'h23;
  localparam logic [ByteW-1:0] ChP    = 8'h50;
  localparam logic [ByteW-1:0] ChBang = 8'h21;
  localparam logic [ByteW-1:0] ChZero = 8'h30;
  localparam logic [ByteW-1:0] ChNine = 8'h39;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPECTED_ID   = 3'd0,
    CFG_ID_FLOOR      = 3'd1,
    CFG_ID_CEILING    = 3'd2,
    CFG_PULSE_FLOOR   = 3'd3,
    CFG_PULSE_CEILING = 3'd4
  } cfg_reg_e;

  // What a cell expects to see before passing its token on
  typedef enum logic [1:0] {
    CELL_ID_DIGIT    = 2'd0,
    CELL_LETTER_P    = 2'd1,
    CELL_PULSE_DIGIT = 2'd2,
    CELL_END         = 2'd3
  } cell_kind_e;

  localparam logic [IdW-1:0]    ExpectedIdRst   = 10'd1;
  localparam logic [IdW-1:0]    IdFloorRst      = 10'd0;
  localparam logic [IdW-1:0]    IdCeilingRst    = 10'd254;
  localparam logic [PulseW-1:0] PulseFloorRst   = 14'd500;
  localparam logic [PulseW-1:0] PulseCeilingRst = 14'd2500;
  // Digits of the reset id, hundreds in the top nibble
  localparam logic [3*DigitW-1:0] IdDigitsRst   = 12'h001;

  function automatic cell_kind_e kind_of(input int unsigned idx);
    cell_kind_e k;
    if (idx < 3) begin
      k = CELL_ID_DIGIT;
    end else if (idx == 3) begin
      k = CELL_LETTER_P;
    end else if (idx < 8) begin
      k = CELL_PULSE_DIGIT;
    end else begin
      k = CELL_END;
    end
    return k;
  endfunction

  // Split an id into decimal digits by reciprocal multiplication.
  // Ids above 999 give a hundreds digit of ten, which no digit byte matches.
  function automatic logic [3*DigitW-1:0] id_digits(input logic [IdW-1:0] v);
    logic [15:0]       p100;
    logic [DigitW-1:0] h;
    logic [IdW-1:0]    r;
    logic [6:0]        rr;
    logic [14:0]       p10;
    logic [DigitW-1:0] t;
    logic [6:0]        o;
    p100 = 16'(v) * 16'd41;
    h    = p100[15:12];
    r    = v - (IdW'(h) * 10'd100);
    rr   = r[6:0];
    p10  = 15'(rr) * 15'd205;
    t    = p10[14:11];
    o    = rr - (7'(t) * 7'd10);
    return {h, t, o[DigitW-1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/spr_cell.sv =====
// One matcher cell: holds the frame token for one position and its pulse value.
`default_nettype none

module spr_cell #(
  parameter spr_pkg::cell_kind_e Kind = spr_pkg::CELL_END
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic                       clear_i,
  input  wire logic [spr_pkg::ByteW-1:0]  byte_i,
  input  wire logic [spr_pkg::DigitW-1:0] ref_digit_i,
  input  wire logic                       tok_i,
  input  wire logic [spr_pkg::PulseW-1:0] val_i,
  output logic                            tok_o,
  output logic                            adv_o,
  output logic [spr_pkg::PulseW-1:0]      val_o
);

  logic                       tok_q;
  logic [spr_pkg::PulseW-1:0] val_q;
  logic                       is_digit;
  logic [spr_pkg::DigitW-1:0] digit;
  logic                       cond;
  logic [17:0]                acc;

  assign is_digit = (byte_i >= spr_pkg::ChZero) && (byte_i <= spr_pkg::ChNine);
  assign digit    = spr_pkg::DigitW'(byte_i - spr_pkg::ChZero);
  assign acc      = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + 18'(digit);

  always_comb begin
    unique case (Kind)
      spr_pkg::CELL_ID_DIGIT: begin
        cond  = is_digit && (digit == ref_digit_i);
        val_o = val_q;
      end
      spr_pkg::CELL_LETTER_P: begin
        cond  = (byte_i == spr_pkg::ChP);
        val_o = '0;
      end
      spr_pkg::CELL_PULSE_DIGIT: begin
        cond  = is_digit;
        val_o = acc[spr_pkg::PulseW-1:0];
      end
      default: begin
        cond  = (byte_i == spr_pkg::ChBang);
        val_o = val_q;
      end
    endcase
  end

  // a hash always restarts, so it never carries a token onward
  assign adv_o = tok_q && cond && (byte_i != spr_pkg::ChHash);
  assign tok_o = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else if (clear_i) begin
      tok_q <= 1'b0;
    end else if (step_i) begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      val_q <= val_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/servo_position_reply_parser.sv =====
// Output: the result is on m_axis in the cycle after the transfer of the last byte.
// Throughput: one byte per cycle; a token moves one cell of the nine-cell chain each byte.
// The output register holds a result until m_axis_tready; input stalls only while it waits.
// Reset: configuration takes its default values, the chain holds no token,
// no frame is kept and no result is pending.
`default_nettype none

module servo_position_reply_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [spr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [spr_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
  input  wire logic                        s_axis_tlast,  // last_byte
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [13:0] position, [15:14] zero
  output logic                             m_axis_tuser   // found
);

  localparam int unsigned N = spr_pkg::NumCells;

  logic [spr_pkg::IdW-1:0]        expected_id_q;
  logic [spr_pkg::IdW-1:0]        id_floor_q;
  logic [spr_pkg::IdW-1:0]        id_ceiling_q;
  logic [spr_pkg::PulseW-1:0]     pulse_floor_q;
  logic [spr_pkg::PulseW-1:0]     pulse_ceiling_q;
  logic [3*spr_pkg::DigitW-1:0]   id_dig_q;

  logic                           hit_q;
  logic [spr_pkg::PulseW-1:0]     hit_pos_q;
  logic                           out_valid_q;
  logic                           out_found_q;
  logic [spr_pkg::PulseW-1:0]     out_pos_q;

  logic                           s_xfer;
  logic                           step;
  logic                           clear;
  logic                           is_hash;
  logic                           id_ok;
  logic                           frame_ok;
  logic                           hit_now;
  logic [spr_pkg::PulseW-1:0]     end_val;

  logic [N-1:0]                   tok;
  logic [N-1:0]                   adv;
  logic [N-1:0]                   cell_tok_in;
  logic [spr_pkg::PulseW-1:0]     val_out [N];
  logic [spr_pkg::PulseW-1:0]     val_in  [N];
  logic [spr_pkg::DigitW-1:0]     ref_dig [N];

  // Configuration registers; id digits are split on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q   <= spr_pkg::ExpectedIdRst;
      id_floor_q      <= spr_pkg::IdFloorRst;
      id_ceiling_q    <= spr_pkg::IdCeilingRst;
      pulse_floor_q   <= spr_pkg::PulseFloorRst;
      pulse_ceiling_q <= spr_pkg::PulseCeilingRst;
      id_dig_q        <= spr_pkg::IdDigitsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spr_pkg::CFG_EXPECTED_ID: begin
          expected_id_q <= cfg_data_i[spr_pkg::IdW-1:0];
          id_dig_q      <= spr_pkg::id_digits(cfg_data_i[spr_pkg::IdW-1:0]);
        end
        spr_pkg::CFG_ID_FLOOR:      id_floor_q      <= cfg_data_i[spr_pkg::IdW-1:0];
        spr_pkg::CFG_ID_CEILING:    id_ceiling_q    <= cfg_data_i[spr_pkg::IdW-1:0];
        spr_pkg::CFG_PULSE_FLOOR:   pulse_floor_q   <= cfg_data_i;
        spr_pkg::CFG_PULSE_CEILING: pulse_ceiling_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  // freeze the chain once a frame is kept
  assign step          = s_xfer && !hit_q;
  assign clear         = s_xfer && s_axis_tlast;
  assign is_hash       = (s_axis_tdata == spr_pkg::ChHash);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ref_dig[i] = '0;
    end
    ref_dig[0] = id_dig_q[11:8];
    ref_dig[1] = id_dig_q[7:4];
    ref_dig[2] = id_dig_q[3:0];
  end

  always_comb begin
    cell_tok_in[0] = is_hash;
    val_in[0]      = '0;
    for (int i = 1; i < N; i++) begin
      cell_tok_in[i] = adv[i-1];
      val_in[i]      = val_out[i-1];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    spr_cell #(
      .Kind(spr_pkg::kind_of(g))
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step),
      .clear_i    (clear),
      .byte_i     (s_axis_tdata),
      .ref_digit_i(ref_dig[g]),
      .tok_i      (cell_tok_in[g]),
      .val_i      (val_in[g]),
      .tok_o      (tok[g]),
      .adv_o      (adv[g]),
      .val_o      (val_out[g])
    );
  end

  assign end_val  = val_out[N-1];
  assign id_ok    = (expected_id_q >= id_floor_q) && (expected_id_q <= id_ceiling_q);
  assign frame_ok = id_ok && (end_val >= pulse_floor_q) && (end_val <= pulse_ceiling_q);
  assign hit_now  = step && adv[N-1] && frame_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (clear) begin
      hit_q <= 1'b0;
    end else if (hit_now) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_now) begin
      hit_pos_q <= end_val;
    end
  end

  // Output register: load on the last byte, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clear) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      out_found_q <= hit_q || hit_now;
      if (hit_q) begin
        out_pos_q <= hit_pos_q;
      end else if (hit_now) begin
        out_pos_q <= end_val;
      end else begin
        out_pos_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {2'b00, out_pos_q};

  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("more than one cell holds a token");

  a_hit_empty_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> (tok == '0))
    else $error("chain holds a token after a frame was kept");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (!hit_q && (tok == '0) && m_axis_tvalid))
    else $error("last byte did not clear the buffer state or load a result");

  a_no_find_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("position is not zero on a result without a frame");

endmodule

`default_nettype wire
